@@ rtl/priority_front_deque_with_cancel_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the priority front deque
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_FRONT_DEQUE_WITH_CANCEL_ASSERT_SVH
`define PRIORITY_FRONT_DEQUE_WITH_CANCEL_ASSERT_SVH

// expression holds at every edge
`define PFDQ_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PFDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define PFDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pfdq_pkg.sv @@
// ---------------------------------------------------------------------------
// pfdq_pkg
// Shared types, codes and command/status structs of the deque.
// ---------------------------------------------------------------------------
`default_nettype none

package pfdq_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned ID_BITS_DEF = 16;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned POS_W       = 2;

  // input actions; codes 5..7 are ignored
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD      = 3'd0,
    ACT_DISPATCH = 3'd1,
    ACT_PEEK     = 3'd2,
    ACT_LIST     = 3'd3,
    ACT_CANCEL   = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED      = 3'd0,
    ST_DISPATCHED = 3'd1,
    ST_PEEKED     = 3'd2,
    ST_LISTED     = 3'd3,
    ST_CANCELLED  = 3'd4,
    ST_EMPTY      = 3'd5,
    ST_NOTFOUND   = 3'd6,
    ST_FULL       = 3'd7
  } status_t;

  typedef enum logic [POS_W-1:0] {
    POS_FRONT  = 2'd0,
    POS_MIDDLE = 2'd1,
    POS_REAR   = 2'd2
  } pos_t;

  // where the result identifier comes from
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_RD   = 2'd1,
    SRC_CMD  = 2'd2
  } id_src_t;

  typedef enum logic [1:0] {
    WR_FRONT = 2'd0,
    WR_REAR  = 2'd1,
    WR_SHIFT = 2'd2
  } wr_sel_t;

  typedef enum logic {
    RD_IDX      = 1'b0,
    RD_IDX_NEXT = 1'b1
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_DECODE   = 4'd1,
    S_RESP     = 4'd2,
    S_LIST_RD  = 4'd3,
    S_LIST_OUT = 4'd4,
    S_SRCH_RD  = 4'd5,
    S_SRCH_CMP = 4'd6,
    S_SHIFT_RD = 4'd7,
    S_SHIFT_WR = 4'd8
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    latch;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    head_inc;
    logic    head_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_set;
    status_t res_status;
    pos_t    res_pos;
    id_src_t res_src;
    logic    out_load;
    logic    out_last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             quick;
    logic             empty;
    logic             full;
    logic             idx_zero;
    logic             idx_last;
    logic             match;
    logic             out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/pfdq_if.sv @@
// ---------------------------------------------------------------------------
// pfdq channel interfaces
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface pfdq_in_if;
  import pfdq_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [ID_W-1:0]  order_id;
  logic             quick;

  modport source (output valid, action, order_id, quick, input ready);
  modport sink   (input valid, action, order_id, quick, output ready);
endinterface

interface pfdq_out_if;
  import pfdq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     result_id;
  logic [POS_W-1:0]    position;
  logic                last;

  modport source (output valid, status, result_id, position, last, input ready);
  modport sink   (input valid, status, result_id, position, last, output ready);
endinterface

`default_nettype wire

@@ rtl/pfdq_ctrl.sv @@
// ---------------------------------------------------------------------------
// pfdq_ctrl
// Sequencer: decodes each command item and steps the datapath through
// reads, writes, the cancel search and the close-up shift.
// ---------------------------------------------------------------------------
`default_nettype none
`include "priority_front_deque_with_cancel_assert.svh"

module pfdq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pfdq_pkg::dp_stat_t stat,
  output pfdq_pkg::dp_cmd_t       cmd
);
  import pfdq_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (stat.act)
          ACT_ADD, ACT_DISPATCH, ACT_PEEK: state_nxt = S_RESP;
          ACT_LIST:   state_nxt = stat.empty ? S_RESP : S_LIST_RD;
          ACT_CANCEL: state_nxt = stat.empty ? S_RESP : S_SRCH_RD;
          default:    state_nxt = S_IDLE;
        endcase
      end
      S_RESP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_LIST_RD: state_nxt = S_LIST_OUT;
      S_LIST_OUT: begin
        if (stat.out_free) state_nxt = stat.idx_last ? S_IDLE : S_LIST_RD;
      end
      S_SRCH_RD: state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (stat.match) begin
          state_nxt = stat.idx_zero ? S_RESP : S_SHIFT_RD;
        end else begin
          state_nxt = stat.idx_last ? S_RESP : S_SRCH_RD;
        end
      end
      S_SHIFT_RD: state_nxt = stat.idx_last ? S_RESP : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.latch   = in_valid;
        cmd.idx_clr = in_valid;
      end
      S_DECODE: begin
        cmd.res_pos = POS_FRONT;
        cmd.res_src = SRC_ZERO;
        case (stat.act)
          ACT_ADD: begin
            cmd.res_set = 1'b1;
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.res_status = ST_ADDED;
              cmd.wr_en      = 1'b1;
              cmd.wr_sel     = stat.quick ? WR_FRONT : WR_REAR;
              cmd.head_dec   = stat.quick;
              cmd.cnt_inc    = 1'b1;
            end
          end
          ACT_DISPATCH: begin
            cmd.res_set = 1'b1;
            if (stat.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.res_status = ST_DISPATCHED;
              cmd.res_src    = SRC_RD;
              cmd.rd_en      = 1'b1;
              cmd.rd_sel     = RD_IDX;
              cmd.head_inc   = 1'b1;
              cmd.cnt_dec    = 1'b1;
            end
          end
          ACT_PEEK: begin
            cmd.res_set = 1'b1;
            if (stat.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.res_status = ST_PEEKED;
              cmd.res_src    = SRC_RD;
              cmd.rd_en      = 1'b1;
              cmd.rd_sel     = RD_IDX;
            end
          end
          ACT_LIST, ACT_CANCEL: begin
            cmd.res_set    = stat.empty;
            cmd.res_status = ST_EMPTY;
          end
          default: cmd.res_set = 1'b0;
        endcase
      end
      S_RESP: begin
        cmd.out_load = stat.out_free;
        cmd.out_last = 1'b1;
      end
      S_LIST_RD: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RD_IDX;
        cmd.res_set    = 1'b1;
        cmd.res_status = ST_LISTED;
        cmd.res_pos    = POS_FRONT;
        cmd.res_src    = SRC_RD;
      end
      S_LIST_OUT: begin
        cmd.out_load = stat.out_free;
        cmd.out_last = stat.idx_last;
        cmd.idx_inc  = stat.out_free && !stat.idx_last;
      end
      S_SRCH_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
      end
      S_SRCH_CMP: begin
        if (stat.match) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_CANCELLED;
          cmd.res_src    = SRC_CMD;
          if (stat.idx_zero) begin
            cmd.res_pos  = POS_FRONT;
            cmd.head_inc = 1'b1;
            cmd.cnt_dec  = 1'b1;
          end else if (stat.idx_last) begin
            cmd.res_pos = POS_REAR;
          end else begin
            cmd.res_pos = POS_MIDDLE;
          end
        end else if (stat.idx_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          cmd.res_pos    = POS_FRONT;
          cmd.res_src    = SRC_ZERO;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        if (stat.idx_last) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_NEXT;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.idx_inc = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  // the final result of an item always returns the sequencer to idle
  `PFDQ_ASSERT_NXT(a_last_to_idle, cmd.out_load && cmd.out_last, state_r == S_IDLE,
    "final result did not return to idle")
  // count and head move one way at a time
  `PFDQ_ASSERT(a_cnt_excl, !(cmd.cnt_inc && cmd.cnt_dec), "count raised and lowered at once")
  `PFDQ_ASSERT(a_head_excl, !(cmd.head_inc && cmd.head_dec), "head moved both ways at once")

endmodule

`default_nettype wire

@@ rtl/pfdq_dp.sv @@
// ---------------------------------------------------------------------------
// pfdq_dp
// Datapath: circular entry memory with head pointer and count, command
// latch, scan index, result holding registers and the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "priority_front_deque_with_cancel_assert.svh"

module pfdq_dp #(
  parameter int unsigned DEPTH   = pfdq_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS = pfdq_pkg::ID_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire pfdq_pkg::dp_cmd_t                cmd,
  output pfdq_pkg::dp_stat_t                    stat,
  input  wire logic [pfdq_pkg::ACT_W-1:0]       in_action,
  input  wire logic [pfdq_pkg::ID_W-1:0]        in_order_id,
  input  wire logic                             in_quick,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic [pfdq_pkg::STATUS_W-1:0]         out_status,
  output logic [pfdq_pkg::ID_W-1:0]             out_result_id,
  output logic [pfdq_pkg::POS_W-1:0]            out_position,
  output logic                                  out_last
);
  import pfdq_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam logic [PW:0]   DEPTH_V   = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic [SW-1:0]    mem [DEPTH];
  logic [SW-1:0]    rd_r;
  logic [PW-1:0]    head_r;
  logic [CW-1:0]    count_r;
  logic [PW-1:0]    idx_r;
  logic [ACT_W-1:0] cmd_act_r;
  logic [SW-1:0]    cmd_id_r;
  logic             cmd_quick_r;
  status_t          res_status_r;
  pos_t             res_pos_r;
  id_src_t          res_src_r;
  logic             out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]  out_id_r;
  logic [POS_W-1:0] out_pos_r;
  logic             out_last_r;

  logic [PW-1:0] head_p1, head_m1, rd_addr, wr_addr;
  logic [SW-1:0] wr_data;
  logic          out_free;

  // slot of an offset from the head, one compare-subtract for the wrap
  function automatic logic [PW-1:0] slot_of(logic [PW-1:0] base, logic [PW-1:0] off);
    logic [PW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_V) s = s - DEPTH_V;
    return s[PW-1:0];
  endfunction

  // pointer and address arithmetic
  always_comb begin
    head_p1 = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
    head_m1 = (head_r == '0) ? LAST_SLOT : head_r - 1'b1;
    rd_addr = slot_of(head_r, (cmd.rd_sel == RD_IDX_NEXT) ? idx_r + 1'b1 : idx_r);
    case (cmd.wr_sel)
      WR_FRONT: wr_addr = head_m1;
      WR_REAR:  wr_addr = slot_of(head_r, count_r[PW-1:0]);
      WR_SHIFT: wr_addr = slot_of(head_r, idx_r);
      default:  wr_addr = slot_of(head_r, idx_r);
    endcase
    wr_data = (cmd.wr_sel == WR_SHIFT) ? rd_r : cmd_id_r;
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_r <= mem[rd_addr];
  end

  // command latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_act_r   <= in_action;
      cmd_id_r    <= in_order_id[SW-1:0];
      cmd_quick_r <= in_quick;
    end
  end

  // head, count and scan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.head_inc) head_r <= head_p1;
      else if (cmd.head_dec) head_r <= head_m1;
      if (cmd.cnt_inc) count_r <= count_r + 1'b1;
      else if (cmd.cnt_dec) count_r <= count_r - 1'b1;
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
    end
  end

  // pending result fields
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_pos_r    <= cmd.res_pos;
      res_src_r    <= cmd.res_src;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_pos_r    <= res_pos_r;
      out_last_r   <= cmd.out_last;
      case (res_src_r)
        SRC_RD:  out_id_r <= ID_W'(rd_r);
        SRC_CMD: out_id_r <= ID_W'(cmd_id_r);
        default: out_id_r <= '0;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_result_id = out_id_r;
  assign out_position  = out_pos_r;
  assign out_last      = out_last_r;

  // status to the sequencer
  always_comb begin
    stat.act      = cmd_act_r;
    stat.quick    = cmd_quick_r;
    stat.empty    = (count_r == '0);
    stat.full     = (count_r == FULL_CNT);
    stat.idx_zero = (idx_r == '0);
    stat.idx_last = ((CW'(idx_r) + 1'b1) == count_r);
    stat.match    = (rd_r == cmd_id_r);
    stat.out_free = out_free;
  end

  `PFDQ_ASSERT(a_count_bound, count_r <= FULL_CNT, "entry count above depth")
  `PFDQ_ASSERT_IMP(a_no_overfill, cmd.cnt_inc, !stat.full, "add into a full deque")
  `PFDQ_ASSERT_IMP(a_no_underflow, cmd.cnt_dec, !stat.empty, "removal from an empty deque")
  `PFDQ_ASSERT_IMP(a_load_free, cmd.out_load, out_free, "output overwritten before taken")

endmodule

`default_nettype wire

@@ rtl/priority_front_deque_with_cancel.sv @@
// Add, dispatch, peek and empty/full answers pass through decode and response states.
// List: each entry is read through the memory read port, then loaded into the output register.
// Cancel: entries are read and compared from the front; those behind a match are closed up.
// One item is in work at a time; the next is taken while the last result waits in the
// output register. Reset (rst_n low, synchronous) empties the deque at once; no clear pass.
// ---------------------------------------------------------------------------
// priority_front_deque_with_cancel
// Bounded deque of order identifiers: quick adds at front, others at rear,
// dispatch, peek, list and cancel by identifier.
// ---------------------------------------------------------------------------
`default_nettype none

module priority_front_deque_with_cancel #(
  parameter int unsigned DEPTH   = pfdq_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS = pfdq_pkg::ID_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pfdq_in_if.sink     in_ch,
  pfdq_out_if.source  out_ch
);
  import pfdq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  pfdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and result path
  pfdq_dp #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_action     (in_ch.action),
    .in_order_id   (in_ch.order_id),
    .in_quick      (in_ch.quick),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_status    (out_ch.status),
    .out_result_id (out_ch.result_id),
    .out_position  (out_ch.position),
    .out_last      (out_ch.last)
  );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Checks the order deque: adds at front and rear, dispatch, peek, list and
// cancel by identifier, against a queue-based copy of the deque kept here.
// A short table of commands runs first. A receiver hold-off then fills the
// block, and a long random mix with bursty commands and stalled replies follows.
// ---------------------------------------------------------------------------
module testbench;
  import pfdq_pkg::*;

  localparam int unsigned DQ_DEPTH       = DEPTH_DEF;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned N_PRESSURE     = 30;
  localparam int unsigned N_RANDOM       = 245;
  localparam int unsigned N_DIR          = 27;

  // reserved action codes, the block drops them
  localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

  typedef struct packed {
    status_t         st;
    logic [ID_W-1:0] rid;
    pos_t            pos;
    logic            last;
  } reply_t;

  // one table row; reps > 1 steps the id and toggles quick per item
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  oid;
    logic             qk;
    logic [4:0]       reps;
    logic             typed;
    status_t          st;
    logic [ID_W-1:0]  rid;
    pos_t             pos;
  } cmd_row_t;

  cmd_row_t cmd_table [N_DIR] = '{
    // every command but add on an empty deque
    '{ACT_DISPATCH, 16'h0000, 1'b0, 5'd1, 1'b1, ST_EMPTY, 16'h0000, POS_FRONT},
    '{ACT_PEEK,     16'hFFFF, 1'b1, 5'd1, 1'b1, ST_EMPTY, 16'h0000, POS_FRONT},
    '{ACT_LIST,     16'h0000, 1'b0, 5'd1, 1'b1, ST_EMPTY, 16'h0000, POS_FRONT},
    '{ACT_CANCEL,   16'hFFFF, 1'b0, 5'd1, 1'b1, ST_EMPTY, 16'h0000, POS_FRONT},
    // id extremes, front and rear adds, a duplicate
    '{ACT_ADD,      16'h0000, 1'b0, 5'd1, 1'b1, ST_ADDED, 16'h0000, POS_FRONT},
    '{ACT_ADD,      16'hFFFF, 1'b1, 5'd1, 1'b1, ST_ADDED, 16'h0000, POS_FRONT},
    '{ACT_ADD,      16'h1234, 1'b0, 5'd1, 1'b1, ST_ADDED, 16'h0000, POS_FRONT},
    '{ACT_ADD,      16'hFFFF, 1'b0, 5'd1, 1'b1, ST_ADDED, 16'h0000, POS_FRONT},
    '{ACT_LIST,     16'h0000, 1'b0, 5'd1, 1'b0, ST_LISTED, 16'h0000, POS_FRONT},
    '{ACT_PEEK,     16'h0000, 1'b0, 5'd1, 1'b0, ST_PEEKED, 16'h0000, POS_FRONT},
    // duplicate: front copy goes first, then the rear one
    '{ACT_CANCEL,   16'hFFFF, 1'b0, 5'd1, 1'b0, ST_CANCELLED, 16'h0000, POS_FRONT},
    '{ACT_CANCEL,   16'hFFFF, 1'b0, 5'd1, 1'b0, ST_CANCELLED, 16'h0000, POS_FRONT},
    '{ACT_CANCEL,   16'hBEEF, 1'b0, 5'd1, 1'b1, ST_NOTFOUND, 16'h0000, POS_FRONT},
    '{ACT_ADD,      16'h5A5A, 1'b1, 5'd1, 1'b1, ST_ADDED, 16'h0000, POS_FRONT},
    '{ACT_CANCEL,   16'h0000, 1'b0, 5'd1, 1'b0, ST_CANCELLED, 16'h0000, POS_FRONT},
    // reserved codes give nothing back
    '{ACT_RSVD5,    16'h0000, 1'b0, 5'd1, 1'b0, ST_ADDED, 16'h0000, POS_FRONT},
    '{ACT_RSVD6,    16'hAAAA, 1'b1, 5'd1, 1'b0, ST_ADDED, 16'h0000, POS_FRONT},
    '{ACT_RSVD7,    16'hFFFF, 1'b1, 5'd1, 1'b0, ST_ADDED, 16'h0000, POS_FRONT},
    '{ACT_DISPATCH, 16'h0000, 1'b0, 5'd1, 1'b0, ST_DISPATCHED, 16'h0000, POS_FRONT},
    // cancel of the only entry reports front
    '{ACT_CANCEL,   16'h1234, 1'b0, 5'd1, 1'b0, ST_CANCELLED, 16'h0000, POS_FRONT},
    '{ACT_PEEK,     16'h0000, 1'b0, 5'd1, 1'b1, ST_EMPTY, 16'h0000, POS_FRONT},
    // fill to the bound, starting with a quick add to an empty deque
    '{ACT_ADD,      16'h8000, 1'b1, 5'd16, 1'b1, ST_ADDED, 16'h0000, POS_FRONT},
    '{ACT_ADD,      16'h7777, 1'b1, 5'd1, 1'b1, ST_FULL, 16'h0000, POS_FRONT},
    '{ACT_LIST,     16'h0000, 1'b0, 5'd1, 1'b0, ST_LISTED, 16'h0000, POS_FRONT},
    '{ACT_CANCEL,   16'h8003, 1'b0, 5'd1, 1'b0, ST_CANCELLED, 16'h0000, POS_FRONT},
    '{ACT_DISPATCH, 16'h0000, 1'b0, 5'd15, 1'b0, ST_DISPATCHED, 16'h0000, POS_FRONT},
    '{ACT_LIST,     16'h0000, 1'b0, 5'd1, 1'b1, ST_EMPTY, 16'h0000, POS_FRONT}
  };

  logic clk;
  logic rst_n;

  pfdq_in_if  in_ch();
  pfdq_out_if out_ch();

  priority_front_deque_with_cancel #(
    .DEPTH   (DQ_DEPTH),
    .ID_BITS (ID_BITS_DEF)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the deque, index 0 is the front
  logic [ID_W-1:0] order_ids [$];
  reply_t          replies_due [$];

  int unsigned err_count     = 0;
  int unsigned cmds_sent     = 0;
  int unsigned cmds_ignored  = 0;
  int unsigned replies_seen  = 0;
  int unsigned full_hits     = 0;
  int unsigned miss_hits     = 0;
  int unsigned longest_list  = 0;
  int unsigned idle_cycles   = 0;

  // sender pacing
  bit          gaps_on    = 1'b1;
  int unsigned burst_left = 0;

  // receiver pattern and long hold-off
  bit          hold_tog   = 1'b0;
  bit          hold_seen  = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned rx_cyc     = 0;
  bit          rx_go;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void owe_reply(status_t st, logic [ID_W-1:0] rid, pos_t pos, logic last);
    reply_t r;
    r = '{st, rid, pos, last};
    replies_due.push_back(r);
  endfunction

  // apply one accepted command to the local deque and queue its replies
  function automatic void queue_update(input logic [ACT_W-1:0] act,
                                       input logic [ID_W-1:0] oid, input logic qk);
    int   n;
    int   hit;
    pos_t where;
    n   = order_ids.size();
    hit = -1;
    case (act)
      ACT_ADD: begin
        if (n >= DQ_DEPTH) begin
          owe_reply(ST_FULL, '0, POS_FRONT, 1'b1);
          full_hits++;
        end else begin
          if (qk) order_ids.push_front(oid);
          else order_ids.push_back(oid);
          owe_reply(ST_ADDED, '0, POS_FRONT, 1'b1);
        end
      end
      ACT_DISPATCH: begin
        if (n == 0) owe_reply(ST_EMPTY, '0, POS_FRONT, 1'b1);
        else owe_reply(ST_DISPATCHED, order_ids.pop_front(), POS_FRONT, 1'b1);
      end
      ACT_PEEK: begin
        if (n == 0) owe_reply(ST_EMPTY, '0, POS_FRONT, 1'b1);
        else owe_reply(ST_PEEKED, order_ids[0], POS_FRONT, 1'b1);
      end
      ACT_LIST: begin
        if (n == 0) owe_reply(ST_EMPTY, '0, POS_FRONT, 1'b1);
        else begin
          for (int i = 0; i < n; i++)
            owe_reply(ST_LISTED, order_ids[i], POS_FRONT, i == n - 1);
          if (n > longest_list) longest_list = n;
        end
      end
      ACT_CANCEL: begin
        if (n == 0) owe_reply(ST_EMPTY, '0, POS_FRONT, 1'b1);
        else begin
          // first match from the front wins
          for (int i = 0; i < n; i++)
            if (hit < 0 && order_ids[i] == oid) hit = i;
          if (hit < 0) begin
            owe_reply(ST_NOTFOUND, '0, POS_FRONT, 1'b1);
            miss_hits++;
          end else begin
            if (hit == 0) where = POS_FRONT;
            else if (hit == n - 1) where = POS_REAR;
            else where = POS_MIDDLE;
            owe_reply(ST_CANCELLED, order_ids[hit], where, 1'b1);
            order_ids.delete(hit);
          end
        end
      end
      default: cmds_ignored++;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch @%0t reply %0d: %s got 0x%0h, want 0x%0h",
               $time, replies_seen, what, got, want);
  endtask

  // offer one command and hold it until taken
  task automatic issue_cmd(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] oid,
                           input logic qk);
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.order_id <= oid;
    in_ch.quick    <= qk;
    do @(posedge clk); while (!in_ch.ready);
    queue_update(act, oid, qk);
    cmds_sent++;
  endtask

  // bursts of back-to-back commands separated by idle gaps
  task automatic pace();
    int unsigned gap;
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, 8);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(0, 11);
      end
    end
  endtask

  // stop sending until every reply is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // small pool for duplicates, extremes, then full range
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return ID_W'($urandom_range(0, 7));
    else if (sel == 3) return ($urandom_range(0, 1) != 0) ? {ID_W{1'b1}} : {ID_W{1'b0}};
    else return ID_W'($urandom);
  endfunction

  // receiver: check each taken reply, then pick next ready
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        replies_seen++;
        if (replies_due.size() == 0) begin
          flag_mismatch("reply with nothing owed", out_ch.status, 0);
        end else begin
          want = replies_due.pop_front();
          if (out_ch.status !== want.st) flag_mismatch("status", out_ch.status, want.st);
          if (out_ch.result_id !== want.rid)
            flag_mismatch("result_id", out_ch.result_id, want.rid);
          if (out_ch.position !== want.pos)
            flag_mismatch("position", out_ch.position, want.pos);
          if (out_ch.last !== want.last) flag_mismatch("last", out_ch.last, want.last);
        end
      end
      rx_cyc++;
      if (hold_tog != hold_seen) begin
        hold_seen = hold_tog;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_go = 1'b0;
      end else begin
        // pattern steps through four modes in turn; mode 0 never stalls
        case ((rx_cyc / 50) % 4)
          0:       rx_go = 1'b1;
          1:       rx_go = (rx_cyc % 4) != 3;
          2:       rx_go = $urandom_range(0, 1);
          default: rx_go = (rx_cyc % 5) == 0;
        endcase
      end
      out_ch.ready <= rx_go;
    end
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d replies owed",
               idle_cycles, replies_due.size());
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cmd_row_t         row;
    reply_t           fixed;
    bit               fill_bias;
    int unsigned      p;
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  oid;
    logic             qk;

    fill_bias       = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_ADD;
    in_ch.order_id  = '0;
    in_ch.quick     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < N_DIR; r++) begin
      row = cmd_table[r];
      for (int k = 0; k < row.reps; k++) begin
        pace();
        issue_cmd(row.act, row.oid + ID_W'(k), row.qk ^ k[0]);
        if (row.typed) begin
          fixed = '{row.st, row.rid, row.pos, 1'b1};
          replies_due[$] = fixed;
        end
      end
    end

    // long receiver hold-off while commands keep coming: block backs up
    wait_drained();
    hold_tog <= ~hold_tog;
    gaps_on  = 1'b0;
    for (int i = 0; i < N_PRESSURE; i++) begin
      if (i % 6 == 5) issue_cmd(ACT_LIST, pick_id(), 1'b0);
      else issue_cmd(ACT_ADD, pick_id(), $urandom_range(0, 1));
    end

    // random mix, alternating between filling and draining
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 45 == 0) fill_bias = ~fill_bias;
      gaps_on = !(i >= 90 && i < 150);
      if (i == 135) wait_drained();
      pace();
      p   = $urandom_range(0, 99);
      oid = pick_id();
      qk  = $urandom_range(0, 1);
      if (p < (fill_bias ? 55 : 25)) begin
        act = ACT_ADD;
      end else if (p < (fill_bias ? 65 : 45)) begin
        act = ACT_DISPATCH;
      end else if (p < (fill_bias ? 72 : 52)) begin
        act = ACT_PEEK;
      end else if (p < (fill_bias ? 80 : 60)) begin
        act = ACT_LIST;
      end else if (p < (fill_bias ? 95 : 93)) begin
        act = ACT_CANCEL;
        // mostly cancel something that is present
        if (order_ids.size() != 0 && $urandom_range(0, 9) < 7)
          oid = order_ids[$urandom_range(0, order_ids.size() - 1)];
      end else begin
        act = ACT_W'($urandom_range(ACT_RSVD5, ACT_RSVD7));
      end
      issue_cmd(act, oid, qk);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d commands (%0d reserved codes), %0d replies checked",
             cmds_sent, cmds_ignored, replies_seen);
    $display("full answers %0d, cancel misses %0d, longest list %0d entries",
             full_hits, miss_hits, longest_list);
    if (err_count == 0 && replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pfdq_pkg.sv
rtl/pfdq_if.sv
rtl/pfdq_ctrl.sv
rtl/pfdq_dp.sv
rtl/priority_front_deque_with_cancel.sv
dv/testbench.sv
